>>> hw/rtl/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types and constants of the palette index expander: colour entry
// layout, write request, luminance weights, output modes, register indexes.
// ----------------------------------------------------------------------------
package pie_pkg;

  // Colour entry as stored: alpha in the top byte, red in the bottom byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  // Palette write travelling from the luminance unit to the memories
  typedef struct packed {
    logic [7:0] slot;
    colour_t    colour;
  } wr_req_t;

  // Luminance weights in Q0.16, summing to one
  localparam logic [23:0] W_RED   = 24'd13938;
  localparam logic [23:0] W_GREEN = 24'd46868;
  localparam logic [23:0] W_BLUE  = 24'd4730;

  // Output modes
  localparam logic [2:0] MODE_LUMA = 3'd0;
  localparam logic [2:0] MODE_RGB  = 3'd1;
  localparam logic [2:0] MODE_BGR  = 3'd2;
  localparam logic [2:0] MODE_RGBA = 3'd3;
  localparam logic [2:0] MODE_BGRA = 3'd4;
  localparam logic [2:0] MODE_PASS = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_DEST_MODE = 2'd0;
  localparam logic [1:0] REG_SRC_BGR   = 2'd1;
  localparam logic [1:0] REG_SRC_ALPHA = 2'd2;
  localparam logic [1:0] REG_ENTRIES   = 2'd3;

  // Request types
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

endpackage

>>> hw/rtl/palette_index_expander.sv
// ----------------------------------------------------------------------------
// palette_index_expander
// Palette lookup: entry writes fill a colour table and a luminance table,
// pixel lookups expand an index into luminance, RGB, BGR, RGBA, BGRA or the
// index itself.
//
//   Channel  Handshake            Payload
//   -------  -------------------  -------------------------------------------
//   in       in_valid/in_ready    req_type, entry_slot, byte_first..fourth,
//                                 pixel_index, last_pixel
//   out      out_valid/out_ready  chan_zero..chan_three, chan_count,
//                                 index_out_of_range, last_out
//   cfg      cfg_write            cfg_index, cfg_data
//
// For a lookup, the table read is registered with the accept, then the
// formatted result enters the output register once the output can take it;
// a new lookup can be accepted while the previous one moves on.
// After an entry write the input is held not ready while the luminance sum
// lands in the tables, so the next request cannot read them before.
// Reset clears control and configuration only; the tables are undefined
// until written. A stalled output holds the read stage and then the input.
// ----------------------------------------------------------------------------
module palette_index_expander #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  // Requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] entry_slot,
  input  logic [7:0] byte_first,
  input  logic [7:0] byte_second,
  input  logic [7:0] byte_third,
  input  logic [7:0] byte_fourth,
  input  logic [7:0] pixel_index,
  input  logic       last_pixel,
  // Results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] chan_zero,
  output logic [7:0] chan_one,
  output logic [7:0] chan_two,
  output logic [7:0] chan_three,
  output logic [2:0] chan_count,
  output logic       index_out_of_range,
  output logic       last_out
);

  localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [8:0]  MaxEnt = 9'(MAX_ENTRIES);

  // Configuration registers
  logic [2:0] dest_mode;
  logic       src_bgr;
  logic       src_alpha;
  logic [8:0] entries;

  // Write path
  logic             wr_go;
  pie_pkg::wr_req_t wr_in;
  logic             wr_busy;
  pie_pkg::wr_req_t wr_mem;
  logic [7:0]       wr_luma;

  // Lookup path
  logic             rd_go;
  logic [8:0]       limit;
  logic             look_valid;
  logic             look_oor;
  logic [7:0]       look_idx;
  logic             look_last;
  logic             look_adv;
  logic             look_free;
  pie_pkg::colour_t rd_colour;
  logic [7:0]       rd_luma;

  // Formatted result
  logic [7:0] c0_next;
  logic [7:0] c1_next;
  logic [7:0] c2_next;
  logic [7:0] c3_next;
  logic [2:0] cnt_next;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mode <= pie_pkg::MODE_LUMA;
      src_bgr   <= 1'b0;
      src_alpha <= 1'b0;
      entries   <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        pie_pkg::REG_DEST_MODE: dest_mode <= cfg_data[2:0];
        pie_pkg::REG_SRC_BGR:   src_bgr   <= cfg_data[0];
        pie_pkg::REG_SRC_ALPHA: src_alpha <= cfg_data[0];
        pie_pkg::REG_ENTRIES:   entries   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a request when the read stage can take one and no write is landing
  assign look_adv  = look_valid && (!out_valid || out_ready);
  assign look_free = !look_valid || look_adv;
  assign in_ready  = look_free && !wr_busy;

  assign rd_go = in_valid && in_ready && (req_type == pie_pkg::REQ_LOOKUP);
  assign wr_go = in_valid && in_ready && (req_type == pie_pkg::REQ_WRITE) &&
                 ({1'b0, entry_slot} < MaxEnt);

  // Reorder the stored bytes to red, green, blue, alpha
  always_comb begin
    wr_in.slot         = entry_slot;
    wr_in.colour.red   = src_bgr ? byte_third : byte_first;
    wr_in.colour.green = byte_second;
    wr_in.colour.blue  = src_bgr ? byte_first : byte_third;
    wr_in.colour.alpha = src_alpha ? byte_fourth : 8'hFF;
  end

  pie_luma u_luma (
    .clk          (clk),
    .rst          (rst),
    .wr_in_valid  (wr_go),
    .wr_in        (wr_in),
    .wr_out_valid (wr_busy),
    .wr_out       (wr_mem),
    .luma         (wr_luma)
  );

  pie_palette_mem #(
    .DEPTH (MAX_ENTRIES)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_busy),
    .wr        (wr_mem),
    .wr_luma   (wr_luma),
    .rd_en     (rd_go),
    .rd_addr   (pixel_index[ADDR_W-1:0]),
    .rd_colour (rd_colour),
    .rd_luma   (rd_luma)
  );

  // Saturate the entry count to the table depth
  assign limit = (entries > MaxEnt) ? MaxEnt : entries;

  // Track the lookup while the table read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else if (rd_go) begin
      look_valid <= 1'b1;
    end else if (look_adv) begin
      look_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      look_oor  <= ({1'b0, pixel_index} >= limit);
      look_idx  <= pixel_index;
      look_last <= last_pixel;
    end
  end

  // Select channels for the output mode; zero them when out of range
  always_comb begin
    c0_next  = 8'd0;
    c1_next  = 8'd0;
    c2_next  = 8'd0;
    c3_next  = 8'd0;
    case (dest_mode)
      pie_pkg::MODE_LUMA: begin
        c0_next  = rd_luma;
        cnt_next = 3'd1;
      end
      pie_pkg::MODE_RGB: begin
        c0_next  = rd_colour.red;
        c1_next  = rd_colour.green;
        c2_next  = rd_colour.blue;
        cnt_next = 3'd3;
      end
      pie_pkg::MODE_BGR: begin
        c0_next  = rd_colour.blue;
        c1_next  = rd_colour.green;
        c2_next  = rd_colour.red;
        cnt_next = 3'd3;
      end
      pie_pkg::MODE_RGBA: begin
        c0_next  = rd_colour.red;
        c1_next  = rd_colour.green;
        c2_next  = rd_colour.blue;
        c3_next  = rd_colour.alpha;
        cnt_next = 3'd4;
      end
      pie_pkg::MODE_BGRA: begin
        c0_next  = rd_colour.blue;
        c1_next  = rd_colour.green;
        c2_next  = rd_colour.red;
        c3_next  = rd_colour.alpha;
        cnt_next = 3'd4;
      end
      default: begin
        // Index passthrough, also for the two unused mode codes
        c0_next  = look_idx;
        cnt_next = 3'd1;
      end
    endcase
    if (look_oor) begin
      c0_next = 8'd0;
      c1_next = 8'd0;
      c2_next = 8'd0;
      c3_next = 8'd0;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (look_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_adv) begin
      chan_zero          <= c0_next;
      chan_one           <= c1_next;
      chan_two           <= c2_next;
      chan_three         <= c3_next;
      chan_count         <= cnt_next;
      index_out_of_range <= look_oor;
      last_out           <= look_last;
    end
  end

endmodule

>>> hw/rtl/pie_luma.sv
// ----------------------------------------------------------------------------
// pie_luma
// Weighted sum of red, green and blue for a palette write. Products are
// registered; the sum and the write request go straight to the memories.
// ----------------------------------------------------------------------------
module pie_luma (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_in_valid,
  input  pie_pkg::wr_req_t wr_in,
  output logic             wr_out_valid,
  output pie_pkg::wr_req_t wr_out,
  output logic [7:0]       luma
);

  logic             busy;
  pie_pkg::wr_req_t req;
  logic [23:0]      prod_r;
  logic [23:0]      prod_g;
  logic [23:0]      prod_b;
  logic [23:0]      sum;

  // Hold the valid flag of the product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= wr_in_valid;
    end
  end

  // Register the three weighted products and the request
  always_ff @(posedge clk) begin
    if (wr_in_valid) begin
      req    <= wr_in;
      prod_r <= 24'(wr_in.colour.red)   * pie_pkg::W_RED;
      prod_g <= 24'(wr_in.colour.green) * pie_pkg::W_GREEN;
      prod_b <= 24'(wr_in.colour.blue)  * pie_pkg::W_BLUE;
    end
  end

  // Add and truncate to the integer part
  assign sum          = prod_r + prod_g + prod_b;
  assign luma         = sum[23:16];
  assign wr_out_valid = busy;
  assign wr_out       = req;

endmodule

>>> hw/rtl/pie_palette_mem.sv
// ----------------------------------------------------------------------------
// pie_palette_mem
// Colour and luminance tables: one write port, one read port with a read
// enable and registered read data that holds while the enable is low.
// ----------------------------------------------------------------------------
module pie_palette_mem #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  pie_pkg::wr_req_t    wr,
  input  logic [7:0]          wr_luma,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pie_pkg::colour_t    rd_colour,
  output logic [7:0]          rd_luma
);

  pie_pkg::colour_t colour_mem [DEPTH];
  logic [7:0]       luma_mem   [DEPTH];

  // Write both tables at the slot of the request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      colour_mem[wr.slot[ADDR_W-1:0]] <= wr.colour;
      luma_mem[wr.slot[ADDR_W-1:0]]   <= wr_luma;
    end
  end

  // Read both tables; hold the data while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_colour <= colour_mem[rd_addr];
      rd_luma   <= luma_mem[rd_addr];
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for palette_index_expander. Palette writes and pixel
// lookups are pushed through the request channel, and a shadow of the colour
// and luminance tables predicts every pixel result. The result channel is
// checked field by field in order. The run covers all output modes, both
// byte orders, alpha on and off, and entry counts from zero past the table
// size. Random back-pressure and request gaps are applied in most phases.
// ----------------------------------------------------------------------------

// One request as offered on the input channel
typedef struct packed {
  logic       kind;
  logic [7:0] slot;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic [7:0] index;
  logic       last;
} palette_req_t;

// One pixel as seen on the result channel
typedef struct packed {
  logic [7:0] c0;
  logic [7:0] c1;
  logic [7:0] c2;
  logic [7:0] c3;
  logic [2:0] count;
  logic       oor;
  logic       last;
} pixel_result_t;

// Shadow of the palette tables and registers, plus the pixels still awaited
class palette_scoreboard #(int unsigned DEPTH = 256);
  pie_pkg::colour_t colours[DEPTH];
  logic [7:0]       lumas[DEPTH];
  logic [2:0]       mode;
  logic             bgr_first;
  logic             has_alpha;
  logic [8:0]       entries;
  pixel_result_t    awaited_pixels[$];
  int unsigned      n_writes;
  int unsigned      n_lookups;
  int unsigned      n_checked;
  int unsigned      n_oor;
  int unsigned      errors;

  function new();
    mode      = pie_pkg::MODE_LUMA;
    bgr_first = 1'b0;
    has_alpha = 1'b0;
    entries   = 9'd256;
    n_writes  = 0;
    n_lookups = 0;
    n_checked = 0;
    n_oor     = 0;
    errors    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [8:0] data);
    case (idx)
      pie_pkg::REG_DEST_MODE: mode = data[2:0];
      pie_pkg::REG_SRC_BGR:   bgr_first = data[0];
      pie_pkg::REG_SRC_ALPHA: has_alpha = data[0];
      pie_pkg::REG_ENTRIES:   entries = data;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return awaited_pixels.size();
  endfunction

  // Update the tables on a write, or queue the expected pixel on a lookup
  function void take_request(palette_req_t r);
    pie_pkg::colour_t c;
    pixel_result_t    e;
    logic [31:0]      weighted;
    logic [8:0]       limit;
    if (r.kind == pie_pkg::REQ_WRITE) begin
      c.green = r.b1;
      c.red   = bgr_first ? r.b2 : r.b0;
      c.blue  = bgr_first ? r.b0 : r.b2;
      c.alpha = has_alpha ? r.b3 : 8'hFF;
      weighted = pie_pkg::W_RED * c.red + pie_pkg::W_GREEN * c.green +
                 pie_pkg::W_BLUE * c.blue;
      colours[r.slot] = c;
      lumas[r.slot]   = weighted[23:16];
      n_writes++;
    end else begin
      limit = (entries > DEPTH) ? DEPTH[8:0] : entries;
      c = colours[r.index];
      e = '0;
      e.last = r.last;
      e.oor  = ({1'b0, r.index} >= limit);
      case (mode)
        pie_pkg::MODE_LUMA: begin
          e.c0 = lumas[r.index];
          e.count = 3'd1;
        end
        pie_pkg::MODE_RGB: begin
          e.c0 = c.red; e.c1 = c.green; e.c2 = c.blue;
          e.count = 3'd3;
        end
        pie_pkg::MODE_BGR: begin
          e.c0 = c.blue; e.c1 = c.green; e.c2 = c.red;
          e.count = 3'd3;
        end
        pie_pkg::MODE_RGBA: begin
          e.c0 = c.red; e.c1 = c.green; e.c2 = c.blue; e.c3 = c.alpha;
          e.count = 3'd4;
        end
        pie_pkg::MODE_BGRA: begin
          e.c0 = c.blue; e.c1 = c.green; e.c2 = c.red; e.c3 = c.alpha;
          e.count = 3'd4;
        end
        // passthrough, and the two spare codes behave the same
        default: begin
          e.c0 = r.index;
          e.count = 3'd1;
        end
      endcase
      // out of range blanks the channels but keeps the mode's count
      if (e.oor) begin
        e.c0 = '0; e.c1 = '0; e.c2 = '0; e.c3 = '0;
      end
      awaited_pixels.push_back(e);
      n_lookups++;
    end
  endfunction

  function void compare(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check one delivered pixel against the oldest expectation
  function void match_pixel(pixel_result_t got);
    pixel_result_t want;
    if (awaited_pixels.size() == 0) begin
      $display("%0t: unexpected pixel, expected none, got chan_zero %0d",
               $time, got.c0);
      errors++;
      return;
    end
    want = awaited_pixels.pop_front();
    n_checked++;
    if (want.oor) n_oor++;
    compare("chan_zero", want.c0, got.c0);
    compare("chan_one", want.c1, got.c1);
    compare("chan_two", want.c2, got.c2);
    compare("chan_three", want.c3, got.c3);
    compare("chan_count", {5'd0, want.count}, {5'd0, got.count});
    compare("index_out_of_range", {7'd0, want.oor}, {7'd0, got.oor});
    compare("last_out", {7'd0, want.last}, {7'd0, got.last});
  endfunction
endclass

module tb;

  localparam int unsigned PALETTE_DEPTH   = 256;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS     = 110;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       req_type;
  logic [7:0] entry_slot;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  logic [7:0] pixel_index;
  logic       last_pixel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] chan_zero;
  logic [7:0] chan_one;
  logic [7:0] chan_two;
  logic [7:0] chan_three;
  logic [2:0] chan_count;
  logic       index_out_of_range;
  logic       last_out;

  palette_scoreboard #(PALETTE_DEPTH) sb;

  // Slots written so far; lookups only ever touch these
  bit          written[PALETTE_DEPTH];
  int unsigned written_slots[$];
  int unsigned n_settings;
  int unsigned cycle_count;
  bit          no_idle;
  bit          hold_off_req;

  palette_index_expander #(
    .MAX_ENTRIES(PALETTE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .entry_slot(entry_slot),
    .byte_first(byte_first),
    .byte_second(byte_second),
    .byte_third(byte_third),
    .byte_fourth(byte_fourth),
    .pixel_index(pixel_index),
    .last_pixel(last_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chan_zero(chan_zero),
    .chan_one(chan_one),
    .chan_two(chan_two),
    .chan_three(chan_three),
    .chan_count(chan_count),
    .index_out_of_range(index_out_of_range),
    .last_out(last_out)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Check every pixel taken from the result channel
  always @(posedge clk) begin : result_monitor
    pixel_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.c0    = chan_zero;
      got.c1    = chan_one;
      got.c2    = chan_two;
      got.c3    = chan_three;
      got.count = chan_count;
      got.oor   = index_out_of_range;
      got.last  = last_out;
      sb.match_pixel(got);
    end
  end

  // Mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Favour the extremes of a byte
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic palette_req_t make_write(input logic [7:0] slot,
      input logic [7:0] b0, b1, b2, b3);
    palette_req_t r;
    r.kind  = pie_pkg::REQ_WRITE;
    r.slot  = slot;
    r.b0    = b0;
    r.b1    = b1;
    r.b2    = b2;
    r.b3    = b3;
    r.index = 8'($urandom_range(255));
    r.last  = 1'($urandom_range(1));
    if (!written[slot]) begin
      written[slot] = 1'b1;
      written_slots.push_back(32'(slot));
    end
    return r;
  endfunction

  function automatic palette_req_t make_lookup(input logic [7:0] idx, input logic last);
    palette_req_t r;
    r.kind  = pie_pkg::REQ_LOOKUP;
    r.slot  = 8'($urandom_range(255));
    r.b0    = 8'($urandom_range(255));
    r.b1    = 8'($urandom_range(255));
    r.b2    = 8'($urandom_range(255));
    r.b3    = 8'($urandom_range(255));
    r.index = idx;
    r.last  = last;
    return r;
  endfunction

  // Roughly a third writes; lookups land on written slots only
  function automatic palette_req_t random_request();
    logic [7:0] idx;
    if ($urandom_range(99) < 30)
      return make_write(8'($urandom_range(255)), pick_byte(), pick_byte(), pick_byte(),
                        pick_byte());
    idx = 8'($urandom_range(255));
    if (!written[idx] || $urandom_range(1) == 0)
      idx = 8'(written_slots[$urandom_range(written_slots.size() - 1)]);
    return make_lookup(idx, $urandom_range(99) < 10);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_req(input palette_req_t r);
    in_valid    <= 1'b1;
    req_type    <= r.kind;
    entry_slot  <= r.slot;
    byte_first  <= r.b0;
    byte_second <= r.b1;
    byte_third  <= r.b2;
    byte_fourth <= r.b3;
    pixel_index <= r.index;
    last_pixel  <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_request(r);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding pixel
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Drain, then let any trailing palette write finish
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [2:0] mode, input logic bgr, alpha,
      input logic [8:0] entries);
    quiesce();
    put_reg(pie_pkg::REG_DEST_MODE, {6'd0, mode});
    put_reg(pie_pkg::REG_SRC_BGR, {8'd0, bgr});
    put_reg(pie_pkg::REG_SRC_ALPHA, {8'd0, alpha});
    put_reg(pie_pkg::REG_ENTRIES, entries);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Extremes, every mode, byte order and alpha, and the entry-count corners
  task automatic run_directed();
    apply_config(pie_pkg::MODE_LUMA, 1'b0, 1'b0, 9'd256);
    send_req(make_write(8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_write(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_write(8'd128, 8'hFF, 8'h00, 8'h00, 8'hAA));
    send_req(make_write(8'd1, 8'h00, 8'hFF, 8'h00, 8'h55));
    send_req(make_write(8'd2, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_req(make_lookup(8'd0, 1'b0));
    send_req(make_lookup(8'd255, 1'b0));
    send_req(make_lookup(8'd128, 1'b0));
    send_req(make_lookup(8'd1, 1'b0));
    send_req(make_lookup(8'd2, 1'b1));
    // every mode code, spare ones included
    for (int m = 0; m < 8; m++) begin
      apply_config(m[2:0], 1'b0, 1'b0, 9'd256);
      send_req(make_lookup(8'd128, m[0]));
    end
    // blue-first source with real alpha
    apply_config(pie_pkg::MODE_BGRA, 1'b1, 1'b1, 9'd256);
    send_req(make_write(8'd3, 8'd10, 8'd20, 8'd30, 8'd40));
    send_req(make_lookup(8'd3, 1'b1));
    // empty palette, single entry, oversize count, one short of full
    apply_config(pie_pkg::MODE_RGB, 1'b1, 1'b1, 9'd0);
    send_req(make_lookup(8'd0, 1'b0));
    apply_config(pie_pkg::MODE_RGB, 1'b1, 1'b1, 9'd1);
    send_req(make_lookup(8'd0, 1'b0));
    send_req(make_lookup(8'd1, 1'b1));
    apply_config(pie_pkg::MODE_RGBA, 1'b1, 1'b1, 9'd511);
    send_req(make_lookup(8'd255, 1'b0));
    apply_config(pie_pkg::MODE_RGBA, 1'b1, 1'b1, 9'd255);
    send_req(make_lookup(8'd255, 1'b1));
  endtask

  task automatic random_phase(input bit steady, input bit with_hold_off);
    no_idle = steady;
    if (with_hold_off) hold_off_req = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // pause the sender once per phase until all pixels are back
      if (n == PHASE_ITEMS / 2) drain();
      send_req(random_request());
      if (!no_idle && !with_hold_off && $urandom_range(99) >= 55) idle_gap(idle_len());
    end
    no_idle = 1'b0;
  endtask

  // Result-side back-pressure, plus the long hold-off on request
  initial begin : result_ready_driver
    int unsigned stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(99) < 20) begin
        out_ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main
    logic [2:0] mode;
    logic       bgr;
    logic       alpha;
    logic [8:0] entries;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    req_type     = pie_pkg::REQ_WRITE;
    entry_slot   = '0;
    byte_first   = '0;
    byte_second  = '0;
    byte_third   = '0;
    byte_fourth  = '0;
    pixel_index  = '0;
    last_pixel   = 1'b0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    n_settings   = 0;
    cycle_count  = 0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    // Sweep settings: all mode codes, both orders, alpha, count extremes
    for (int p = 0; p < PHASES; p++) begin
      mode  = (p < 8) ? p[2:0] : 3'($urandom_range(7));
      bgr   = (p < 4) ? p[0] : 1'($urandom_range(1));
      alpha = (p < 4) ? p[1] : 1'($urandom_range(1));
      case (p)
        0: entries = 9'd256;
        1: entries = 9'd1;
        2: entries = 9'd0;
        3: entries = 9'd511;
        4: entries = 9'd255;
        5: entries = 9'($urandom_range(2, 255));
        6: entries = 9'd257;
        7: entries = 9'd256;
        8: entries = 9'($urandom_range(511));
        default: entries = 9'($urandom_range(1, 256));
      endcase
      apply_config(mode, bgr, alpha, entries);
      random_phase(p == 3, p == 5 || p == 8);
    end

    quiesce();
    $display("Ran %0d palette writes and %0d lookups over %0d register settings,",
             sb.n_writes, sb.n_lookups, n_settings);
    $display("covering all mode codes; %0d pixels checked, %0d out of range, %0d errors.",
             sb.n_checked, sb.n_oor, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pie_pkg.sv
hw/rtl/pie_luma.sv
hw/rtl/pie_palette_mem.sv
hw/rtl/palette_index_expander.sv
tb/sv/tb.sv
